// ----- rtl/core/dpsr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsr_pkg: shared types and helpers for the disc progress shock recovery
// Disc time type, command and status codes, register indexes, and the
// time add and compare functions used by the step logic.
// ----------------------------------------------------------------------------
package dpsr_pkg;

    // Command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    // Seek engine status codes (anything else reads as busy)
    localparam logic [1:0] SEEK_BUSY  = 2'd0;
    localparam logic [1:0] SEEK_READY = 2'd1;
    localparam logic [1:0] SEEK_ERROR = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SINGLE_SPEED = 2'd0;
    localparam logic [1:0] CFG_TICKS_SINGLE = 2'd1;
    localparam logic [1:0] CFG_TICKS_DOUBLE = 2'd2;

    // Configuration reset values
    localparam logic       RST_SINGLE_SPEED = 1'b1;
    localparam logic [7:0] RST_TICKS_SINGLE = 8'd40;
    localparam logic [7:0] RST_TICKS_DOUBLE = 8'd20;

    // Progress window and seek-back offset, in frames
    localparam logic [5:0] WINDOW_LO_FRAMES = 6'h0F;
    localparam logic [5:0] SEEK_BACK_FRAMES = 6'h28;

    // Disc time radixes
    localparam logic [7:0] FRAMES_PER_SEC   = 8'd75;
    localparam logic [7:0] FRAMES_PER_SEC2  = 8'd150;
    localparam logic [6:0] SECS_PER_MIN     = 7'd60;
    localparam logic [7:0] MINS_WRAP        = 8'd100;

    typedef struct packed {
        logic [6:0] minute;
        logic [5:0] second;
        logic [6:0] frame;
    } dtime_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       abs_time_valid;
        logic       in_leadin;
        dtime_t     pos;
        logic [1:0] seek_status;
    } item_t;

    typedef struct packed {
        logic       mute;
        logic       seek_request;
        dtime_t     seek;
        logic       armed;
        logic       recovering;
    } result_t;

    typedef struct packed {
        logic       active;
        logic       recovery;
        logic [7:0] slice_timer;
        dtime_t     ref_time;
        logic       mute;
    } state_t;

    // a + sadd seconds + fadd frames, normalized; minutes wrap at 100.
    // Raw inputs keep every intermediate below twice its radix (three
    // times for frames), so compare-and-subtract is enough.
    function automatic dtime_t time_add(dtime_t a, logic sadd, logic [5:0] fadd);
        logic [7:0] fs;
        logic [1:0] fcarry;
        logic [6:0] ss;
        logic       scarry;
        logic [7:0] ms;
        dtime_t     r;
        fs = {1'b0, a.frame} + {2'b00, fadd};
        if (fs >= FRAMES_PER_SEC2)
        begin
            fcarry = 2'd2;
            fs = fs - FRAMES_PER_SEC2;
        end
        else if (fs >= FRAMES_PER_SEC)
        begin
            fcarry = 2'd1;
            fs = fs - FRAMES_PER_SEC;
        end
        else
        begin
            fcarry = 2'd0;
        end
        ss = {1'b0, a.second} + {6'd0, sadd} + {5'd0, fcarry};
        scarry = (ss >= SECS_PER_MIN);
        if (scarry)
        begin
            ss = ss - SECS_PER_MIN;
        end
        ms = {1'b0, a.minute} + {7'd0, scarry};
        if (ms >= MINS_WRAP)
        begin
            ms = ms - MINS_WRAP;
        end
        r.minute = ms[6:0];
        r.second = ss[5:0];
        r.frame  = fs[6:0];
        return r;
    endfunction

    // Lexicographic a > b on raw fields
    function automatic logic time_gt(dtime_t a, dtime_t b);
        logic gt;
        if (a.minute != b.minute)
        begin
            gt = (a.minute > b.minute);
        end
        else if (a.second != b.second)
        begin
            gt = (a.second > b.second);
        end
        else
        begin
            gt = (a.frame > b.frame);
        end
        return gt;
    endfunction

endpackage

// ----- rtl/core/dpsr_item_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsr_item_if: input item channel
// Valid/ready channel carrying one command with subcode time and seek status.
// ----------------------------------------------------------------------------
interface dpsr_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic       abs_time_valid;
    logic       in_leadin;
    logic [6:0] pos_min;
    logic [5:0] pos_sec;
    logic [6:0] pos_frame;
    logic [1:0] seek_status;

    modport source (output valid, cmd, abs_time_valid, in_leadin, pos_min, pos_sec,
                    pos_frame, seek_status, input ready);
    modport sink (input valid, cmd, abs_time_valid, in_leadin, pos_min, pos_sec,
                  pos_frame, seek_status, output ready);
endinterface

// ----- rtl/core/dpsr_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsr_result_if: result channel
// Valid/ready channel carrying mute, seek request and detector status.
// ----------------------------------------------------------------------------
interface dpsr_result_if;
    logic       valid;
    logic       ready;
    logic       mute;
    logic       seek_request;
    logic [6:0] seek_min;
    logic [5:0] seek_sec;
    logic [6:0] seek_frame;
    logic       armed;
    logic       recovering;

    modport source (output valid, mute, seek_request, seek_min, seek_sec, seek_frame,
                    armed, recovering, input ready);
    modport sink (input valid, mute, seek_request, seek_min, seek_sec, seek_frame,
                  armed, recovering, output ready);
endinterface

// ----- rtl/core/dpsr_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsr_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface dpsr_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/disc_progress_shock_recovery.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disc_progress_shock_recovery: disc progress shock detector
// Slice-timed progress check on disc time with mute and seek-back recovery.
// ----------------------------------------------------------------------------
// Every accepted item (tick, start or stop) yields exactly one result; it
// passes through the input register and then the result register. One item
// is accepted per cycle unless a held result stalls the input; the detector
// state update lies between the input register and the result register.
// A held result stalls the input only once the input register is also full.
// Configuration writes are always accepted and should be issued while no
// item is in flight.
// ----------------------------------------------------------------------------
module disc_progress_shock_recovery
    import dpsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dpsr_item_if.sink   item,
    dpsr_result_if.source result,
    dpsr_cfg_if.sink    cfg
);

    logic       item_valid_reg;
    item_t      item_reg;
    logic       result_valid_reg;
    result_t    result_reg;
    state_t     state_reg;
    state_t     state_next;
    result_t    step_result;
    logic [7:0] slice_len;
    logic       advance;
    item_t      item_in;

    // Configuration registers
    assign cfg.ready = 1'b1;

    dpsr_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (cfg.valid),
        .wr_index  (cfg.index),
        .wr_data   (cfg.data),
        .slice_len (slice_len)
    );

    // Pipeline control
    assign advance    = item_valid_reg && (!result_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || advance;

    assign item_in = {item.cmd, item.abs_time_valid, item.in_leadin, item.pos_min,
                      item.pos_sec, item.pos_frame, item.seek_status};

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            item_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg <= item_in;
        end
    end

    // Step logic
    dpsr_step u_step (
        .item       (item_reg),
        .state      (state_reg),
        .slice_len  (slice_len),
        .state_next (state_next),
        .result     (step_result)
    );

    // Detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    assign result.valid        = result_valid_reg;
    assign result.mute         = result_reg.mute;
    assign result.seek_request = result_reg.seek_request;
    assign result.seek_min     = result_reg.seek.minute;
    assign result.seek_sec     = result_reg.seek.second;
    assign result.seek_frame   = result_reg.seek.frame;
    assign result.armed        = result_reg.armed;
    assign result.recovering   = result_reg.recovering;

`ifndef SYNTHESIS
    // recovery always runs with audio muted
    a_recovery_muted: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.recovery |-> state_reg.mute)
        else $error("recovery without mute");

    // state moves only when an item is processed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without an item");

    // a seek is only requested by an armed detector
    a_seek_armed: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.seek_request) |-> result_reg.armed)
        else $error("seek request while disarmed");

    // seek target is zero without a request, normalized with one
    a_seek_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |->
            (result_reg.seek_request ?
                (result_reg.seek.frame < 7'd75 && result_reg.seek.second < 6'd60 &&
                 result_reg.seek.minute < 7'd100) :
                (result_reg.seek == '0)))
        else $error("bad seek target");
`endif

endmodule

// ----- rtl/core/dpsr_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsr_cfg_regs: configuration registers
// Holds speed select and both slice lengths; drives the active slice length.
// ----------------------------------------------------------------------------
module dpsr_cfg_regs
    import dpsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic [1:0] wr_index,
    input  logic [7:0] wr_data,
    output logic [7:0] slice_len
);

    logic       single_speed_reg;
    logic [7:0] ticks_single_reg;
    logic [7:0] ticks_double_reg;

    // Register writes; an unused index is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            single_speed_reg <= RST_SINGLE_SPEED;
            ticks_single_reg <= RST_TICKS_SINGLE;
            ticks_double_reg <= RST_TICKS_DOUBLE;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_SINGLE_SPEED: single_speed_reg <= wr_data[0];
                CFG_TICKS_SINGLE: ticks_single_reg <= wr_data;
                CFG_TICKS_DOUBLE: ticks_double_reg <= wr_data;
                default:          ;
            endcase
        end
    end

    assign slice_len = single_speed_reg ? ticks_single_reg : ticks_double_reg;

endmodule

// ----- rtl/core/dpsr_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsr_step: detector step logic
// Next detector state and the result for one registered item.
// ----------------------------------------------------------------------------
module dpsr_step
    import dpsr_pkg::*;
(
    input  item_t      item,
    input  state_t     state,
    input  logic [7:0] slice_len,
    output state_t     state_next,
    output result_t    result
);

    logic [7:0] timer_dec;
    dtime_t     win_lo;
    dtime_t     win_hi;
    dtime_t     target;
    logic       in_window;

    // Timer countdown, plus the time window and seek target from the current reference
    assign timer_dec = (state.slice_timer != 8'd0) ? state.slice_timer - 8'd1 : 8'd0;
    assign win_lo    = time_add(state.ref_time, 1'b0, WINDOW_LO_FRAMES);
    assign win_hi    = time_add(state.ref_time, 1'b1, 6'd0);
    assign target    = time_add(state.ref_time, 1'b0, SEEK_BACK_FRAMES);
    assign in_window = time_gt(item.pos, win_lo) && !time_gt(item.pos, win_hi);

    always_comb
    begin
        state_next          = state;
        result.seek_request = 1'b0;
        result.seek         = '0;
        case (item.cmd)
            CMD_START:
            begin
                state_next.slice_timer = slice_len;
                state_next.ref_time    = item.pos;
                state_next.active      = 1'b1;
                state_next.recovery    = 1'b0;
            end
            CMD_STOP:
            begin
                state_next.active = 1'b0;
            end
            CMD_TICK:
            begin
                state_next.slice_timer = timer_dec;
                if (state.active)
                begin
                    // slice-end progress check
                    if (!state.recovery && timer_dec == 8'd0)
                    begin
                        if (item.abs_time_valid)
                        begin
                            if (in_window)
                            begin
                                state_next.slice_timer = slice_len;
                                state_next.ref_time    = item.pos;
                            end
                            else
                            begin
                                state_next.recovery = 1'b1;
                                state_next.mute     = 1'b1;
                            end
                        end
                        else if (item.in_leadin)
                        begin
                            state_next.recovery = 1'b1;
                            state_next.mute     = 1'b1;
                        end
                    end
                    // seek-back request while recovering
                    if (state_next.recovery)
                    begin
                        result.seek_request = 1'b1;
                        result.seek         = target;
                        case (item.seek_status)
                            SEEK_READY:
                            begin
                                state_next.recovery    = 1'b0;
                                state_next.slice_timer = slice_len;
                                state_next.ref_time    = item.pos;
                                state_next.mute        = 1'b0;
                            end
                            SEEK_ERROR:
                            begin
                                state_next.ref_time = target;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            default: ;
        endcase
        result.mute       = state_next.mute;
        result.armed      = state_next.active;
        result.recovering = state_next.recovery;
    end

endmodule
